// ----- hw/rtl/multi_pool_buffer_deque_manager_macros.svh -----
// Assertion macros shared by the checker of the buffer deque manager.
`ifndef MULTI_POOL_BUFFER_DEQUE_MANAGER_MACROS_SVH
`define MULTI_POOL_BUFFER_DEQUE_MANAGER_MACROS_SVH

// Condition that holds at every edge outside reset.
`define MPBDQ_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequent that holds in the same cycle as the antecedent.
`define MPBDQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent that holds in the cycle after the antecedent.
`define MPBDQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/mpbdq_pkg.sv -----
// Types and constants of the multi-pool buffer deque manager.
package mpbdq_pkg;

   localparam int MODE_W     = 3;
   localparam int POOL_SEL_W = 3;
   localparam int BUF_ID_W   = 8;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 9;

   typedef logic [BUF_ID_W-1:0] buf_id_type;
   typedef logic [COUNT_W-1:0]  count_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUT_HEAD  = 3'd0,
      MODE_PUT_TAIL  = 3'd1,
      MODE_GET_HEAD  = 3'd2,
      MODE_GET_TAIL  = 3'd3,
      MODE_PEEK_HEAD = 3'd4,
      MODE_PEEK_TAIL = 3'd5,
      MODE_REMOVE    = 3'd6
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_EMPTY   = 2'd1,
      STAT_INVALID = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_DECODE,
      S_PUT_HEAD,
      S_PUT_TAIL,
      S_PUT_LINK,
      S_GET_HEAD,
      S_GET_TAIL,
      S_RM_POOL,
      S_UL_START,
      S_UL_NEXT,
      S_UL_PREV,
      S_UL_FREE,
      S_DONE
   } state_type;

endpackage

// ----- hw/rtl/mpbdq_ram.sv -----
// Simple dual-port synchronous RAM with registered read.
module mpbdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/multi_pool_buffer_deque_manager.sv -----
// Multi-pool buffer deque manager: top level with link sequencer and response register.
//
// Keeps buffer IDs in NUM_POOLS pools, each a circular doubly linked deque. Per-buffer
// state {pooled, owner, next, prev} lives in one RAM of NUM_BUFFERS words; per-pool
// state {head, size} lives in a second RAM of NUM_POOLS words. The tail of a pool is
// the prev link of its head. Both RAMs have a registered read and share a single write
// port each, so a sequencer walks every word through read, modify and write-back, one
// buffer word per cycle. One request word is in flight at a time. A request with no
// link change (invalid request, empty pool, peek head, put into an empty pool) goes
// from decode to done; peek tail reads the head word. A put into a single-entry pool
// rewrites the head, then links the new buffer; into a longer pool it rewrites the
// head, then the tail, then links the new buffer. A get or remove relinks the next and
// prev neighbors when the pool holds more than two entries, then frees the buffer; get
// tail first finds the tail through the head. The buffer RAM write port takes the
// rewrites of the buffer and of its two neighbors in turn. A finished response waits
// in an output register, so a new request is taken while the previous response is
// stalled. After reset the block runs a clearing pass over max(NUM_BUFFERS, NUM_POOLS)
// words that zeroes both RAMs; req_stall stays high throughout. Status codes: ok, pool
// empty (result buffer and count zero), invalid (buffer already pooled on put, not
// pooled on remove, pool or buffer out of range, or unused mode).
module multi_pool_buffer_deque_manager #(
   parameter int NUM_BUFFERS = 256,
   parameter int NUM_POOLS   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mpbdq_pkg::MODE_W-1:0]        req_mode,
   input  logic [mpbdq_pkg::POOL_SEL_W-1:0]    req_pool_select,
   input  logic [mpbdq_pkg::BUF_ID_W-1:0]      req_buffer_id,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mpbdq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [mpbdq_pkg::BUF_ID_W-1:0]      rsp_result_buffer,
   output logic [mpbdq_pkg::COUNT_W-1:0]       rsp_pool_count
);

   // Widths of buffer index, pool index and pool size.
   localparam int IW = $clog2(NUM_BUFFERS);
   localparam int PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int CW = $clog2(NUM_BUFFERS + 1);

   // Buffer word: {pooled, owner, next, prev}. Pool word: {head, size}.
   localparam int BUF_W   = 1 + PW + 2 * IW;
   localparam int POOL_W  = IW + CW;
   localparam int B_POOLED = BUF_W - 1;
   localparam int B_OWNER  = 2 * IW;
   localparam int B_NEXT   = IW;
   localparam int B_PREV   = 0;
   localparam int P_HEAD   = CW;

   // Clearing pass covers the larger of the two RAMs.
   localparam int CLR_DEPTH = (NUM_BUFFERS > NUM_POOLS) ? NUM_BUFFERS : NUM_POOLS;
   localparam int CLRW      = $clog2(CLR_DEPTH);

   function automatic logic [BUF_W-1:0] buf_word(input logic          pooled,
                                                 input logic [PW-1:0] owner,
                                                 input logic [IW-1:0] nxt,
                                                 input logic [IW-1:0] prv);
      return {pooled, owner, nxt, prv};
   endfunction

   // Sequencer state.
   mpbdq_pkg::state_type   state_ff, state_in;
   logic [CLRW-1:0]        clr_ff, clr_in;

   // Request context and link scratch registers.
   mpbdq_pkg::mode_type    mode_ff, mode_in;
   logic                   bad_ff, bad_in;
   mpbdq_pkg::buf_id_type  id_ff, id_in;
   logic [IW-1:0]          bidx_ff, bidx_in;
   logic [PW-1:0]          pool_ff, pool_in;
   logic [IW-1:0]          head_ff, head_in;
   logic [CW-1:0]          size_ff, size_in;
   logic [IW-1:0]          cur_ff, cur_in;
   logic [IW-1:0]          nxt_ff, nxt_in;
   logic [IW-1:0]          prv_ff, prv_in;

   // Finished result, then the output register.
   mpbdq_pkg::status_type  res_status_ff, res_status_in;
   mpbdq_pkg::buf_id_type  res_rbuf_ff, res_rbuf_in;
   mpbdq_pkg::count_type   res_count_ff, res_count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mpbdq_pkg::status_type  rsp_status_ff, rsp_status_in;
   mpbdq_pkg::buf_id_type  rsp_rbuf_ff, rsp_rbuf_in;
   mpbdq_pkg::count_type   rsp_count_ff, rsp_count_in;

   // RAM ports.
   logic                   buf_we;
   logic [IW-1:0]          buf_waddr;
   logic [BUF_W-1:0]       buf_wdata;
   logic [IW-1:0]          buf_raddr;
   logic [BUF_W-1:0]       buf_rdata;
   logic                   pool_we;
   logic [PW-1:0]          pool_waddr;
   logic [POOL_W-1:0]      pool_wdata;
   logic [PW-1:0]          pool_raddr;
   logic [POOL_W-1:0]      pool_rdata;

   // Fields of the words read last cycle.
   logic                   rd_pooled;
   logic [PW-1:0]          rd_owner;
   logic [IW-1:0]          rd_next;
   logic [IW-1:0]          rd_prev;
   logic [IW-1:0]          rd_head;
   logic [CW-1:0]          rd_size;

   // Request decode and handshake.
   logic                   accept;
   logic                   out_free;
   logic                   load_out;
   logic                   clr_last;
   logic                   id_ok;
   logic                   pool_ok;
   logic                   req_bad;
   logic [IW-1:0]          req_idx;
   logic [PW-1:0]          req_pool;

   mpbdq_ram #(
      .WIDTH (BUF_W),
      .DEPTH (NUM_BUFFERS)
   ) u_buf_ram (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   mpbdq_ram #(
      .WIDTH (POOL_W),
      .DEPTH (NUM_POOLS)
   ) u_pool_ram (
      .clock   (clock),
      .wr_en   (pool_we),
      .wr_addr (pool_waddr),
      .wr_data (pool_wdata),
      .rd_addr (pool_raddr),
      .rd_data (pool_rdata)
   );

   assign rd_pooled = buf_rdata[B_POOLED];
   assign rd_owner  = buf_rdata[B_OWNER +: PW];
   assign rd_next   = buf_rdata[B_NEXT +: IW];
   assign rd_prev   = buf_rdata[B_PREV +: IW];
   assign rd_head   = pool_rdata[P_HEAD +: IW];
   assign rd_size   = pool_rdata[CW-1:0];

   // Take a request when idle, or when a finished word moves into a free output register.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == mpbdq_pkg::S_IDLE) ||
                        ((state_ff == mpbdq_pkg::S_DONE) && out_free));
   assign accept    = req_valid && !req_stall;
   assign load_out  = (state_ff == mpbdq_pkg::S_DONE) && out_free;
   assign clr_last  = (int'(clr_ff) == CLR_DEPTH - 1);

   assign id_ok    = int'(req_buffer_id) < NUM_BUFFERS;
   assign pool_ok  = int'(req_pool_select) < NUM_POOLS;
   assign req_idx  = IW'(req_buffer_id);
   assign req_pool = PW'(req_pool_select);

   // Flag range and mode errors up front so the sequencer only answers them.
   always_comb begin
      case (mpbdq_pkg::mode_type'(req_mode))
         mpbdq_pkg::MODE_PUT_HEAD,
         mpbdq_pkg::MODE_PUT_TAIL:  req_bad = !(id_ok && pool_ok);
         mpbdq_pkg::MODE_GET_HEAD,
         mpbdq_pkg::MODE_GET_TAIL,
         mpbdq_pkg::MODE_PEEK_HEAD,
         mpbdq_pkg::MODE_PEEK_TAIL: req_bad = !pool_ok;
         mpbdq_pkg::MODE_REMOVE:    req_bad = !id_ok;
         default:                   req_bad = 1'b1;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpbdq_pkg::S_IDLE: begin
            if (accept) begin
               state_in = mpbdq_pkg::S_DECODE;
            end
         end
         mpbdq_pkg::S_CLEAR: begin
            if (clr_last) begin
               state_in = mpbdq_pkg::S_IDLE;
            end
         end
         mpbdq_pkg::S_DECODE: begin
            state_in = mpbdq_pkg::S_DONE;
            if (!bad_ff) begin
               if (mode_ff inside {mpbdq_pkg::MODE_PUT_HEAD, mpbdq_pkg::MODE_PUT_TAIL}) begin
                  if (!rd_pooled && (rd_size != '0)) begin
                     state_in = mpbdq_pkg::S_PUT_HEAD;
                  end
               end else if (mode_ff inside {mpbdq_pkg::MODE_GET_HEAD, mpbdq_pkg::MODE_GET_TAIL,
                                            mpbdq_pkg::MODE_PEEK_TAIL}) begin
                  if (rd_size != '0) begin
                     state_in = mpbdq_pkg::S_GET_HEAD;
                  end
               end else if (mode_ff == mpbdq_pkg::MODE_REMOVE) begin
                  if (rd_pooled) begin
                     state_in = mpbdq_pkg::S_RM_POOL;
                  end
               end
            end
         end
         mpbdq_pkg::S_PUT_HEAD: begin
            if (size_ff == CW'(1)) begin
               state_in = mpbdq_pkg::S_PUT_LINK;
            end else begin
               state_in = mpbdq_pkg::S_PUT_TAIL;
            end
         end
         mpbdq_pkg::S_PUT_TAIL: state_in = mpbdq_pkg::S_PUT_LINK;
         mpbdq_pkg::S_PUT_LINK: state_in = mpbdq_pkg::S_DONE;
         mpbdq_pkg::S_GET_HEAD: begin
            case (mode_ff)
               mpbdq_pkg::MODE_GET_HEAD: state_in = mpbdq_pkg::S_UL_START;
               mpbdq_pkg::MODE_GET_TAIL: state_in = mpbdq_pkg::S_GET_TAIL;
               default:                  state_in = mpbdq_pkg::S_DONE;
            endcase
         end
         mpbdq_pkg::S_GET_TAIL: state_in = mpbdq_pkg::S_UL_START;
         mpbdq_pkg::S_RM_POOL:  state_in = mpbdq_pkg::S_UL_START;
         mpbdq_pkg::S_UL_START: begin
            if (size_ff > CW'(2)) begin
               state_in = mpbdq_pkg::S_UL_NEXT;
            end else begin
               state_in = mpbdq_pkg::S_UL_FREE;
            end
         end
         mpbdq_pkg::S_UL_NEXT: state_in = mpbdq_pkg::S_UL_PREV;
         mpbdq_pkg::S_UL_PREV: state_in = mpbdq_pkg::S_UL_FREE;
         mpbdq_pkg::S_UL_FREE: state_in = mpbdq_pkg::S_DONE;
         mpbdq_pkg::S_DONE: begin
            if (accept) begin
               state_in = mpbdq_pkg::S_DECODE;
            end else if (out_free) begin
               state_in = mpbdq_pkg::S_IDLE;
            end
         end
         default: state_in = mpbdq_pkg::S_IDLE;
      endcase
   end

   // RAM accesses, scratch registers and result.
   always_comb begin
      clr_in        = clr_ff;
      mode_in       = mode_ff;
      bad_in        = bad_ff;
      id_in         = id_ff;
      bidx_in       = bidx_ff;
      pool_in       = pool_ff;
      head_in       = head_ff;
      size_in       = size_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      prv_in        = prv_ff;
      res_status_in = res_status_ff;
      res_rbuf_in   = res_rbuf_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_rbuf_in   = rsp_rbuf_ff;
      rsp_count_in  = rsp_count_ff;

      buf_we     = 1'b0;
      buf_waddr  = cur_ff;
      buf_wdata  = '0;
      buf_raddr  = req_idx;
      pool_we    = 1'b0;
      pool_waddr = pool_ff;
      pool_wdata = '0;
      pool_raddr = req_pool;

      // Capture the request; its buffer and pool words are read in the same cycle.
      if (accept) begin
         mode_in = mpbdq_pkg::mode_type'(req_mode);
         bad_in  = req_bad;
         id_in   = req_buffer_id;
         bidx_in = req_idx;
         pool_in = req_pool;
      end

      // Move the finished word into the output register.
      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_rbuf_in   = res_rbuf_ff;
         rsp_count_in  = res_count_ff;
      end

      case (state_ff)
         mpbdq_pkg::S_CLEAR: begin
            buf_we     = int'(clr_ff) < NUM_BUFFERS;
            buf_waddr  = IW'(clr_ff);
            pool_we    = int'(clr_ff) < NUM_POOLS;
            pool_waddr = PW'(clr_ff);
            clr_in     = clr_ff + 1'b1;
         end
         mpbdq_pkg::S_DECODE: begin
            head_in       = rd_head;
            size_in       = rd_size;
            res_status_in = mpbdq_pkg::STAT_INVALID;
            res_rbuf_in   = id_ff;
            res_count_in  = '0;
            if (!bad_ff) begin
               case (mode_ff)
                  mpbdq_pkg::MODE_PUT_HEAD,
                  mpbdq_pkg::MODE_PUT_TAIL: begin
                     res_count_in = mpbdq_pkg::count_type'(rd_size);
                     if (!rd_pooled && (rd_size == '0)) begin
                        // Empty pool: the buffer links to itself and becomes head.
                        buf_we        = 1'b1;
                        buf_waddr     = bidx_ff;
                        buf_wdata     = buf_word(1'b1, pool_ff, bidx_ff, bidx_ff);
                        pool_we       = 1'b1;
                        pool_wdata    = {bidx_ff, CW'(1)};
                        res_status_in = mpbdq_pkg::STAT_OK;
                        res_count_in  = mpbdq_pkg::count_type'(1);
                     end else if (!rd_pooled) begin
                        buf_raddr = rd_head;
                     end
                  end
                  mpbdq_pkg::MODE_GET_HEAD,
                  mpbdq_pkg::MODE_GET_TAIL,
                  mpbdq_pkg::MODE_PEEK_HEAD,
                  mpbdq_pkg::MODE_PEEK_TAIL: begin
                     if (rd_size == '0) begin
                        res_status_in = mpbdq_pkg::STAT_EMPTY;
                        res_rbuf_in   = '0;
                     end else begin
                        // Peek head answers from the pool word; the rest need the head word.
                        res_status_in = mpbdq_pkg::STAT_OK;
                        res_rbuf_in   = mpbdq_pkg::buf_id_type'(rd_head);
                        res_count_in  = mpbdq_pkg::count_type'(rd_size);
                        buf_raddr     = rd_head;
                     end
                  end
                  mpbdq_pkg::MODE_REMOVE: begin
                     if (rd_pooled) begin
                        pool_in    = rd_owner;
                        pool_raddr = rd_owner;
                        cur_in     = bidx_ff;
                        nxt_in     = rd_next;
                        prv_in     = rd_prev;
                     end
                  end
                  default: begin
                     res_status_in = mpbdq_pkg::STAT_INVALID;
                  end
               endcase
            end
         end
         mpbdq_pkg::S_PUT_HEAD: begin
            // Point the head's prev at the new buffer; with a single entry the head is
            // also the tail, so both its links change in this one write.
            buf_we    = 1'b1;
            buf_waddr = head_ff;
            if (size_ff == CW'(1)) begin
               buf_wdata = buf_word(1'b1, rd_owner, bidx_ff, bidx_ff);
               prv_in    = head_ff;
            end else begin
               buf_wdata = buf_word(rd_pooled, rd_owner, rd_next, bidx_ff);
               buf_raddr = rd_prev;
               prv_in    = rd_prev;
            end
         end
         mpbdq_pkg::S_PUT_TAIL: begin
            buf_we    = 1'b1;
            buf_waddr = prv_ff;
            buf_wdata = buf_word(rd_pooled, rd_owner, bidx_ff, rd_prev);
         end
         mpbdq_pkg::S_PUT_LINK: begin
            buf_we        = 1'b1;
            buf_waddr     = bidx_ff;
            buf_wdata     = buf_word(1'b1, pool_ff, head_ff, prv_ff);
            pool_we       = 1'b1;
            pool_wdata    = {(mode_ff == mpbdq_pkg::MODE_PUT_HEAD) ? bidx_ff : head_ff,
                             CW'(size_ff + 1'b1)};
            res_status_in = mpbdq_pkg::STAT_OK;
            res_rbuf_in   = id_ff;
            res_count_in  = mpbdq_pkg::count_type'(CW'(size_ff + 1'b1));
         end
         mpbdq_pkg::S_GET_HEAD: begin
            case (mode_ff)
               mpbdq_pkg::MODE_GET_HEAD: begin
                  cur_in = head_ff;
                  nxt_in = rd_next;
                  prv_in = rd_prev;
               end
               mpbdq_pkg::MODE_GET_TAIL: begin
                  cur_in    = rd_prev;
                  buf_raddr = rd_prev;
               end
               default: begin
                  res_rbuf_in = mpbdq_pkg::buf_id_type'(rd_prev);
               end
            endcase
         end
         mpbdq_pkg::S_GET_TAIL: begin
            nxt_in = rd_next;
            prv_in = rd_prev;
         end
         mpbdq_pkg::S_RM_POOL: begin
            head_in = rd_head;
            size_in = rd_size;
         end
         mpbdq_pkg::S_UL_START: begin
            // Two entries: the survivor points at itself, no read needed.
            if (size_ff > CW'(2)) begin
               buf_raddr = nxt_ff;
            end else if (size_ff == CW'(2)) begin
               buf_we    = 1'b1;
               buf_waddr = nxt_ff;
               buf_wdata = buf_word(1'b1, pool_ff, nxt_ff, nxt_ff);
            end
         end
         mpbdq_pkg::S_UL_NEXT: begin
            buf_we    = 1'b1;
            buf_waddr = nxt_ff;
            buf_wdata = buf_word(rd_pooled, rd_owner, rd_next, prv_ff);
            buf_raddr = prv_ff;
         end
         mpbdq_pkg::S_UL_PREV: begin
            buf_we    = 1'b1;
            buf_waddr = prv_ff;
            buf_wdata = buf_word(rd_pooled, rd_owner, nxt_ff, rd_prev);
         end
         mpbdq_pkg::S_UL_FREE: begin
            // Drop the buffer from its pool; advance the head past it if it was the head.
            buf_we        = 1'b1;
            buf_waddr     = cur_ff;
            buf_wdata     = '0;
            pool_we       = 1'b1;
            pool_wdata    = {(head_ff == cur_ff) ? nxt_ff : head_ff, CW'(size_ff - 1'b1)};
            res_status_in = mpbdq_pkg::STAT_OK;
            res_rbuf_in   = mpbdq_pkg::buf_id_type'(cur_ff);
            res_count_in  = mpbdq_pkg::count_type'(CW'(size_ff - 1'b1));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpbdq_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      bad_ff        <= bad_in;
      id_ff         <= id_in;
      bidx_ff       <= bidx_in;
      pool_ff       <= pool_in;
      head_ff       <= head_in;
      size_ff       <= size_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      prv_ff        <= prv_in;
      res_status_ff <= res_status_in;
      res_rbuf_ff   <= res_rbuf_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rbuf_ff   <= rsp_rbuf_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_buffer = rsp_rbuf_ff;
   assign rsp_pool_count    = rsp_count_ff;

endmodule

// ----- hw/rtl/mpbdq_checker.sv -----
// Port-level checker of the buffer deque manager and its bind.
`include "multi_pool_buffer_deque_manager_macros.svh"

module mpbdq_checker #(
   parameter int NUM_BUFFERS = 256
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [mpbdq_pkg::STATUS_W-1:0]    rsp_status,
   input logic [mpbdq_pkg::BUF_ID_W-1:0]    rsp_result_buffer,
   input logic [mpbdq_pkg::COUNT_W-1:0]     rsp_pool_count
);

   // Hold a stalled response word.
   `MPBDQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_result_buffer) && $stable(rsp_pool_count), "stalled response word changed")

   // One request in flight: the cycle after a take, the input side stalls.
   `MPBDQ_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall, "request taken while another is in flight")

   // An empty pool answers with zero buffer and zero count.
   `MPBDQ_ASSERT_SAME(a_empty_zero, rsp_valid && (rsp_status == mpbdq_pkg::STAT_EMPTY), (rsp_result_buffer == '0) && (rsp_pool_count == '0), "empty status with nonzero payload")

   // A pool never holds more than all buffers.
   `MPBDQ_ASSERT_HOLDS(a_count_bound, !rsp_valid || (int'(rsp_pool_count) <= NUM_BUFFERS), "pool count exceeds buffer count")

endmodule

bind multi_pool_buffer_deque_manager mpbdq_checker #(
   .NUM_BUFFERS (NUM_BUFFERS)
) u_mpbdq_checker (.*);
